@@ design/ath_pkg.sv @@
package ath_pkg;

  // Request type codes as they arrive on the request channel.
  localparam logic REQ_RECORD  = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned CNT32_W = 32;
  localparam int unsigned TOT_W   = 64;
  localparam int unsigned PROBE_W = 11;

  localparam logic [PROBE_W-1:0] PROBE_SAT = 11'd2047;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RECORD,
    OP_RELEASE
  } op_e;

  // Event handed from the sequencer to the statistics registers.
  typedef struct packed {
    logic               clear;
    logic               update;
    op_e                op;
    logic               hit;
    logic [SIZE_W-1:0]  size;
    logic [PROBE_W-1:0] probe;
  } stat_evt_t;

  typedef struct packed {
    logic [CNT32_W-1:0] live;
    logic [TOT_W-1:0]   alloc_total;
    logic [TOT_W-1:0]   free_total;
    logic [CNT32_W-1:0] miss;
    logic [PROBE_W-1:0] max_add;
  } stat_t;

endpackage

@@ design/ath_req_if.sv @@
interface ath_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ath_pkg::ADDR_W-1:0]  address;
  logic [ath_pkg::SIZE_W-1:0]  alloc_size;

  modport source (output valid, req_type, address, alloc_size, input ready);
  modport sink (input valid, req_type, address, alloc_size, output ready);
endinterface

@@ design/ath_rsp_if.sv @@
interface ath_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ath_pkg::SIZE_W-1:0]   freed_size;
  logic                         hit;
  logic [ath_pkg::PROBE_W-1:0]  probe_count;
  logic [ath_pkg::CNT32_W-1:0]  live_count;
  logic [ath_pkg::TOT_W-1:0]    bytes_allocated;
  logic [ath_pkg::TOT_W-1:0]    bytes_freed;
  logic [ath_pkg::CNT32_W-1:0]  not_found_count;
  logic [ath_pkg::PROBE_W-1:0]  longest_add_probe;
  logic                         half_full_crossed;

  modport source (
    output valid, freed_size, hit, probe_count, live_count, bytes_allocated,
           bytes_freed, not_found_count, longest_add_probe, half_full_crossed,
    input  ready
  );
  modport sink (
    input  valid, freed_size, hit, probe_count, live_count, bytes_allocated,
           bytes_freed, not_found_count, longest_add_probe, half_full_crossed,
    output ready
  );
endinterface

@@ design/ath_ram.sv @@
module ath_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ath_hash_step.sv @@
// One step of the home-slot search. The value is shifted right until its two
// low bits are not both zero; whole runs of eight zero bits go in one step.
module ath_hash_step #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic [ath_pkg::ADDR_W-1:0] v_i,
  output logic [ath_pkg::ADDR_W-1:0] v_o,
  output logic                       done_o,
  output logic [INDEX_BITS-1:0]      idx_o
);

  logic [3:0]                 tz;
  logic [2:0]                 sh;
  logic [ath_pkg::ADDR_W-1:0] shifted;

  always_comb begin
    tz = 4'd0;
    for (int i = 8; i >= 0; i--) begin
      if (v_i[i]) begin
        tz = 4'(i);
      end
    end
    sh      = (tz >= 4'd2) ? 3'(tz - 4'd1) : 3'd0;
    shifted = v_i >> sh;

    v_o    = v_i;
    done_o = 1'b1;
    idx_o  = '0;
    if (v_i != '0) begin
      if (v_i[8:0] == 9'd0) begin
        v_o    = v_i >> 8;
        done_o = 1'b0;
      end else begin
        idx_o = shifted[INDEX_BITS-1:0];
      end
    end
  end

endmodule

@@ design/ath_stats.sv @@
// Statistics registers. Every counter saturates; the live count stops at zero.
module ath_stats #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ath_pkg::stat_evt_t evt_i,
  output ath_pkg::stat_t     cur_o,
  output ath_pkg::stat_t     nxt_o,
  output logic               crossed_o
);

  localparam logic [ath_pkg::CNT32_W-1:0] HW_RESET =
      ath_pkg::CNT32_W'(((2 ** INDEX_BITS) - 1) / 2);

  ath_pkg::stat_t                stat_q, stat_d;
  logic [ath_pkg::CNT32_W-1:0]   hw_q, hw_d;
  logic [ath_pkg::TOT_W:0]       sum;
  logic [ath_pkg::TOT_W-1:0]     base;
  logic [ath_pkg::TOT_W-1:0]     sat_sum;
  logic [ath_pkg::CNT32_W-1:0]   live_inc;

  always_comb begin
    base = (evt_i.op == ath_pkg::OP_RECORD) ? stat_q.alloc_total : stat_q.free_total;
    sum  = {1'b0, base} + {{(ath_pkg::TOT_W - ath_pkg::SIZE_W + 1){1'b0}}, evt_i.size};
    sat_sum  = sum[ath_pkg::TOT_W] ? '1 : sum[ath_pkg::TOT_W-1:0];
    live_inc = (stat_q.live == '1) ? stat_q.live : stat_q.live + 1'b1;

    stat_d    = stat_q;
    hw_d      = hw_q;
    crossed_o = 1'b0;
    case (evt_i.op)
      ath_pkg::OP_RECORD: begin
        stat_d.live        = live_inc;
        stat_d.alloc_total = sat_sum;
        if (live_inc > hw_q) begin
          hw_d      = live_inc;
          crossed_o = 1'b1;
        end
        if (evt_i.hit && (evt_i.probe > stat_q.max_add)) begin
          stat_d.max_add = evt_i.probe;
        end
      end
      ath_pkg::OP_RELEASE: begin
        if (evt_i.hit) begin
          stat_d.free_total = sat_sum;
          if (stat_q.live != '0) begin
            stat_d.live = stat_q.live - 1'b1;
          end
        end else if (stat_q.miss != '1) begin
          stat_d.miss = stat_q.miss + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
      hw_q   <= HW_RESET;
    end else if (evt_i.clear) begin
      stat_q <= '0;
      hw_q   <= HW_RESET;
    end else if (evt_i.update) begin
      stat_q <= stat_d;
      hw_q   <= hw_d;
    end
  end

  assign cur_o = stat_q;
  assign nxt_o = stat_d;

endmodule

@@ design/allocation_tracker_hash_table.sv @@
// Allocation tracker: an open-addressed hash table with linear probing that
// holds the start address and size of every live allocation. A record beat
// counts the allocation, adds its bytes and stores it in the first empty slot
// from its home slot on; a release beat searches no further than the longest
// probe any record has needed, clears the matching slot and returns its size.
// Each request beat produces exactly one response beat carrying the running
// counters. Requests are handled one at a time. A request is accepted; if
// tracking is on and its address is nonzero, it is then hashed, with one more
// hash step for each full eight trailing zero bits of the address past its
// lowest two, the table read is started and the probed slots are checked one
// after another. Then the response is posted. The probe loop reads through
// the slot memories' single read port. The response register frees the
// sequencer, so a new request is taken while the previous response still
// waits on rsp_o. Writing 1 to the enable register while tracking is off
// clears all counters and, if the sequencer is idle, runs a clearing pass
// over all 2**INDEX_BITS slots of the table, during which no request is
// accepted. Requests while tracking is off change nothing.
module allocation_tracker_hash_table #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  ath_req_if.sink       req_i,
  ath_rsp_if.source     rsp_o
);

  localparam int unsigned DEPTH = 2 ** INDEX_BITS;
  // The probe counter must hold both the table size and one past the
  // saturated longest probe.
  localparam int unsigned CNT_W = (INDEX_BITS + 1 > 12) ? INDEX_BITS + 1 : 12;
  localparam logic [INDEX_BITS-1:0] IDX_MASK = '1;

  ath_pkg::state_e state_q, state_d;

  logic                         en_q, en_d;
  logic                         start_clr;
  logic [INDEX_BITS-1:0]        clr_idx_q, clr_idx_d;
  ath_pkg::op_e                 op_q, op_d;
  logic [ath_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [ath_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [ath_pkg::ADDR_W-1:0]   v_q, v_d;
  logic [INDEX_BITS-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         hit_q, hit_d;
  logic [ath_pkg::SIZE_W-1:0]   freed_q, freed_d;

  // Slot memories.
  logic                         ram_we;
  logic [INDEX_BITS-1:0]        ram_waddr;
  logic [ath_pkg::ADDR_W-1:0]   ram_wdata_addr;
  logic                         size_we;
  logic [INDEX_BITS-1:0]        ram_raddr;
  logic [ath_pkg::ADDR_W-1:0]   slot_addr;
  logic [ath_pkg::SIZE_W-1:0]   slot_size;

  // Hash step.
  logic [ath_pkg::ADDR_W-1:0]   hash_v;
  logic                         hash_done;
  logic [INDEX_BITS-1:0]        hash_idx;

  // Statistics.
  ath_pkg::stat_evt_t           evt;
  ath_pkg::stat_t               stat_cur, stat_nxt;
  logic                         crossed;

  // Probe loop decisions.
  logic                         accept;
  logic                         load;
  logic                         chk_stop;
  logic [ath_pkg::PROBE_W-1:0]  probe_sat;

  // Response register.
  logic                         out_valid_q;
  logic [ath_pkg::SIZE_W-1:0]   out_freed_q;
  logic                         out_hit_q;
  logic [ath_pkg::PROBE_W-1:0]  out_probe_q;
  ath_pkg::stat_t               out_stat_q;
  logic                         out_crossed_q;

  // A write of 1 while tracking is off starts a fresh session.
  assign start_clr = cfg_we_i && cfg_wdata_i && !en_q;
  assign en_d      = cfg_we_i ? cfg_wdata_i : en_q;

  assign req_i.ready = (state_q == ath_pkg::ST_IDLE) && !start_clr;
  assign accept      = req_i.valid && req_i.ready;
  assign load        = (state_q == ath_pkg::ST_FINISH) && (!out_valid_q || rsp_o.ready);

  assign probe_sat = (cnt_q > CNT_W'(ath_pkg::PROBE_SAT)) ? ath_pkg::PROBE_SAT
                                                            : cnt_q[ath_pkg::PROBE_W-1:0];

  // The probe loop ends on an empty slot or a full sweep for a record, and on
  // a match or the longest add probe for a release.
  always_comb begin
    if (op_q == ath_pkg::OP_RECORD) begin
      chk_stop = (slot_addr == '0) || (cnt_q == CNT_W'(IDX_MASK));
    end else begin
      chk_stop = (slot_addr == addr_q) || (cnt_q == CNT_W'(stat_cur.max_add));
    end
  end

  ath_hash_step #(
    .INDEX_BITS(INDEX_BITS)
  ) u_hash (
    .v_i   (v_q),
    .v_o   (hash_v),
    .done_o(hash_done),
    .idx_o (hash_idx)
  );

  ath_ram #(
    .WIDTH(ath_pkg::ADDR_W),
    .DEPTH(DEPTH)
  ) u_addr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata_addr),
    .raddr_i(ram_raddr),
    .rdata_o(slot_addr)
  );

  ath_ram #(
    .WIDTH(ath_pkg::SIZE_W),
    .DEPTH(DEPTH)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (size_we),
    .waddr_i(ram_waddr),
    .wdata_i(size_q),
    .raddr_i(ram_raddr),
    .rdata_o(slot_size)
  );

  ath_stats #(
    .INDEX_BITS(INDEX_BITS)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt),
    .cur_o    (stat_cur),
    .nxt_o    (stat_nxt),
    .crossed_o(crossed)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ath_pkg::ST_IDLE: begin
        if (start_clr) begin
          state_d = ath_pkg::ST_CLEAR;
        end else if (accept) begin
          if (en_q && (req_i.address != '0)) begin
            state_d = ath_pkg::ST_HASH;
          end else begin
            state_d = ath_pkg::ST_FINISH;
          end
        end
      end
      ath_pkg::ST_CLEAR: begin
        if (!start_clr && (clr_idx_q == IDX_MASK)) begin
          state_d = ath_pkg::ST_IDLE;
        end
      end
      ath_pkg::ST_HASH: begin
        if (hash_done) begin
          state_d = ath_pkg::ST_PROBE_RD;
        end
      end
      ath_pkg::ST_PROBE_RD: begin
        state_d = ath_pkg::ST_PROBE_CHK;
      end
      ath_pkg::ST_PROBE_CHK: begin
        if (chk_stop) begin
          state_d = ath_pkg::ST_FINISH;
        end
      end
      ath_pkg::ST_FINISH: begin
        if (load) begin
          state_d = ath_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ath_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_idx_d      = clr_idx_q;
    op_d           = op_q;
    addr_d         = addr_q;
    size_d         = size_q;
    v_d            = v_q;
    idx_d          = idx_q;
    cnt_d          = cnt_q;
    hit_d          = hit_q;
    freed_d        = freed_q;
    ram_we         = 1'b0;
    size_we        = 1'b0;
    ram_waddr      = idx_q;
    ram_wdata_addr = '0;
    ram_raddr      = idx_q;

    unique case (state_q)
      ath_pkg::ST_IDLE: begin
        clr_idx_d = '0;
        if (accept) begin
          addr_d  = req_i.address;
          size_d  = req_i.alloc_size;
          v_d     = {1'b0, req_i.address[ath_pkg::ADDR_W-1:1]};
          cnt_d   = '0;
          hit_d   = 1'b0;
          freed_d = '0;
          if (!en_q) begin
            op_d = ath_pkg::OP_NONE;
          end else if (req_i.req_type == ath_pkg::REQ_RECORD) begin
            op_d = ath_pkg::OP_RECORD;
          end else if (req_i.address != '0) begin
            op_d = ath_pkg::OP_RELEASE;
          end else begin
            op_d = ath_pkg::OP_NONE;
          end
        end
      end
      ath_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        clr_idx_d = start_clr ? '0 : clr_idx_q + 1'b1;
      end
      ath_pkg::ST_HASH: begin
        v_d = hash_v;
        if (hash_done) begin
          idx_d = hash_idx;
        end
      end
      ath_pkg::ST_PROBE_RD: begin
        ram_raddr = idx_q;
      end
      ath_pkg::ST_PROBE_CHK: begin
        // Read the next slot ahead so that one slot is checked every cycle.
        ram_raddr = idx_q + 1'b1;
        if (op_q == ath_pkg::OP_RECORD) begin
          if (slot_addr == '0) begin
            ram_we         = 1'b1;
            size_we        = 1'b1;
            ram_wdata_addr = addr_q;
            hit_d          = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end else begin
          if (slot_addr == addr_q) begin
            ram_we  = 1'b1;
            hit_d   = 1'b1;
            freed_d = slot_size;
          end else begin
            cnt_d = cnt_q + 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ath_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    evt        = '0;
    evt.clear  = start_clr;
    evt.update = load;
    evt.op     = op_q;
    evt.hit    = hit_q;
    evt.size   = (op_q == ath_pkg::OP_RECORD) ? size_q : freed_q;
    evt.probe  = probe_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ath_pkg::ST_IDLE;
      en_q        <= 1'b0;
      clr_idx_q   <= '0;
      op_q        <= ath_pkg::OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      en_q      <= en_d;
      clr_idx_q <= clr_idx_d;
      op_q      <= op_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    size_q  <= size_d;
    v_q     <= v_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    hit_q   <= hit_d;
    freed_q <= freed_d;
    if (load) begin
      out_freed_q   <= (op_q == ath_pkg::OP_RELEASE && hit_q) ? freed_q : '0;
      out_hit_q     <= hit_q;
      out_probe_q   <= (op_q == ath_pkg::OP_NONE) ? '0 : probe_sat;
      out_stat_q    <= stat_nxt;
      out_crossed_q <= crossed;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.freed_size        = out_freed_q;
  assign rsp_o.hit               = out_hit_q;
  assign rsp_o.probe_count       = out_probe_q;
  assign rsp_o.live_count        = out_stat_q.live;
  assign rsp_o.bytes_allocated   = out_stat_q.alloc_total;
  assign rsp_o.bytes_freed       = out_stat_q.free_total;
  assign rsp_o.not_found_count   = out_stat_q.miss;
  assign rsp_o.longest_add_probe = out_stat_q.max_add;
  assign rsp_o.half_full_crossed = out_crossed_q;

endmodule
